// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the rtl file bitmap_block_allocator.sv
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock edge out of reset
`define BBA_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define BBA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define BBA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// types and constants of the bitmap block allocator
// ---------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   localparam int DEF_GROUP_COUNT    = 4;
   localparam int DEF_BITS_PER_GROUP = 1024;

   localparam int WORD_BITS  = 32;
   localparam int WORD_SHIFT = 5;
   localparam int LOCAL_W    = 10;
   localparam int GROUP_IN_W = 2;
   localparam int BLOCK_W    = 12;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NONE_FREE = 2'd1,
      STAT_RANGE     = 2'd2
   } status_type;

   typedef struct packed {
      logic                  mode;
      logic [GROUP_IN_W-1:0] alloc_group;
      logic [BLOCK_W-1:0]    freed_block;
   } req_type;

   typedef struct packed {
      logic [LOCAL_W-1:0] local_index;
      status_type         status;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/bba_ram.sv
// ---------------------------------------------------------------------------
// bba_ram
// bitmap word store, one write port and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
   parameter int DEPTH = 128
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [bba_pkg::WORD_BITS-1:0]          wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [bba_pkg::WORD_BITS-1:0]          rd_data
);

   logic [bba_pkg::WORD_BITS-1:0] mem_ff [DEPTH];
   logic [bba_pkg::WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_block_allocator.sv
// ---------------------------------------------------------------------------
// bitmap_block_allocator
// per-group block allocator: find-first-zero over a word bitmap, free counters
// ---------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   req_     in   req_valid/req_ready    bba_pkg::req_type  (mode, group, block)
//   rsp_     out  rsp_valid/rsp_ready    bba_pkg::rsp_type  (local index, status)
//
// allocate: a zero counter or an absent group goes straight to the result;
//   else the scan reads one word per cycle, up to WPG = bitmap words per group
// free: repeated subtraction of BITS_PER_GROUP gives group and local index,
//   then a read-modify-write of the word
// req_ready is high only while idle, so one request is worked on at a time;
//   reset runs a clearing pass over all GROUP_COUNT*WPG words first
// the sequencer takes the next request in while an earlier result waits on
//   rsp_ready; a second finished result holds req_ready low
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bitmap_block_allocator #(
   parameter int GROUP_COUNT    = bba_pkg::DEF_GROUP_COUNT,
   parameter int BITS_PER_GROUP = bba_pkg::DEF_BITS_PER_GROUP
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bba_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bba_pkg::rsp_type      rsp_payload
);

   // sizes derived from the parameters
   localparam int WPG    = (BITS_PER_GROUP + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
   localparam int DEPTH  = GROUP_COUNT * WPG;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_W = (WPG > 1) ? $clog2(WPG) : 1;
   localparam int GRP_W  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int CNT_W  = $clog2(BITS_PER_GROUP + 1);
   localparam int REM_W  = (CNT_W > bba_pkg::BLOCK_W) ? CNT_W : bba_pkg::BLOCK_W;
   localparam int TAIL   = BITS_PER_GROUP % bba_pkg::WORD_BITS;

   localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(WPG - 1);
   localparam logic [GRP_W-1:0]  GRP_LAST  = GRP_W'(GROUP_COUNT - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(BITS_PER_GROUP);
   localparam logic [REM_W-1:0]  REM_BPG   = REM_W'(BITS_PER_GROUP);
   // only the last word of a group may hold bits past the group's end
   localparam logic [bba_pkg::WORD_BITS-1:0] LAST_MASK =
      (TAIL == 0) ? {bba_pkg::WORD_BITS{1'b1}} :
                    ((bba_pkg::WORD_BITS'(1) << TAIL) - bba_pkg::WORD_BITS'(1));

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DIVIDE,
      S_FREE_WR,
      S_DONE
   } state_type;

   // first word address of a group
   function automatic logic [ADDR_W-1:0] group_base(input logic [GRP_W-1:0] g);
      group_base = ADDR_W'(int'(g) * WPG);
   endfunction

   // bit position of a one-hot word
   function automatic logic [bba_pkg::WORD_SHIFT-1:0] onehot_pos(
      input logic [bba_pkg::WORD_BITS-1:0] oh
   );
      logic [bba_pkg::WORD_SHIFT-1:0] pos;
      pos = '0;
      for (int i = 0; i < bba_pkg::WORD_BITS; i++) begin
         if (oh[i]) begin
            pos = pos | bba_pkg::WORD_SHIFT'(i);
         end
      end
      onehot_pos = pos;
   endfunction

   // sequencer and datapath registers
   state_type          state_ff,  state_in;
   logic [ADDR_W-1:0]  addr_ff,   addr_in;    // word address, also clear pointer
   logic [WORD_W-1:0]  word_ff,   word_in;    // word within group under check
   logic [GRP_W-1:0]   grp_ff,    grp_in;
   logic [REM_W-1:0]   rem_ff,    rem_in;     // running remainder of the block number
   logic [CNT_W-1:0]   cnt_ff [GROUP_COUNT];
   logic [CNT_W-1:0]   cnt_in [GROUP_COUNT];
   bba_pkg::rsp_type   res_ff,    res_in;
   bba_pkg::rsp_type   rsp_ff,    rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // ram port
   logic                          ram_we;
   logic [ADDR_W-1:0]             ram_waddr;
   logic [bba_pkg::WORD_BITS-1:0] ram_wdata;
   logic                          ram_re;
   logic [ADDR_W-1:0]             ram_raddr;
   logic [bba_pkg::WORD_BITS-1:0] ram_rdata;

   // scan unit
   logic [bba_pkg::WORD_BITS-1:0] avail;
   logic [bba_pkg::WORD_BITS-1:0] lowest;
   logic [bba_pkg::WORD_BITS-1:0] local_wide;
   logic                          req_fire;
   logic                          alloc_present;
   logic [GRP_W-1:0]              req_grp;
   logic [CNT_W-1:0]              req_cnt;

   bba_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // requested group and its counter; an absent group never reaches the counter
   assign alloc_present = int'(req_payload.alloc_group) < GROUP_COUNT;
   assign req_grp       = GRP_W'(req_payload.alloc_group);
   assign req_cnt       = alloc_present ? cnt_ff[req_grp] : '0;

   // free bits of the word read last cycle, and the lowest of them
   assign avail  = ~ram_rdata & ((word_ff == WORD_LAST) ? LAST_MASK
                                                        : {bba_pkg::WORD_BITS{1'b1}});
   assign lowest = avail & (~avail + bba_pkg::WORD_BITS'(1));
   assign local_wide = (bba_pkg::WORD_BITS'(word_ff) << bba_pkg::WORD_SHIFT)
                     | bba_pkg::WORD_BITS'(onehot_pos(lowest));

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      word_in      = word_ff;
      grp_in       = grp_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = addr_ff;

      // result register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            // zero one word per cycle after reset
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = '0;
            addr_in   = ADDR_W'(addr_ff + 1'b1);
            if (addr_ff == ADDR_LAST) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               res_in.local_index = '0;
               res_in.status      = bba_pkg::STAT_OK;
               if (req_payload.mode == bba_pkg::MODE_ALLOC) begin
                  if (!alloc_present || req_cnt == '0) begin
                     res_in.status = bba_pkg::STAT_NONE_FREE;
                     state_in      = S_DONE;
                  end else begin
                     // start the scan with word 0 of the group
                     grp_in    = req_grp;
                     word_in   = '0;
                     addr_in   = group_base(req_grp);
                     ram_re    = 1'b1;
                     ram_raddr = group_base(req_grp);
                     state_in  = S_SCAN;
                  end
               end else begin
                  rem_in   = REM_W'(req_payload.freed_block);
                  grp_in   = '0;
                  state_in = S_DIVIDE;
               end
            end
         end

         S_SCAN: begin
            if (avail != '0) begin
               // take the lowest free bit of this word
               ram_we             = 1'b1;
               ram_waddr          = addr_ff;
               ram_wdata          = ram_rdata | lowest;
               cnt_in[grp_ff]     = CNT_W'(cnt_ff[grp_ff] - 1'b1);
               res_in.local_index = local_wide[bba_pkg::LOCAL_W-1:0];
               res_in.status      = bba_pkg::STAT_OK;
               state_in           = S_DONE;
            end else if (word_ff == WORD_LAST) begin
               // bitmap full although the counter said otherwise
               res_in.local_index = '0;
               res_in.status      = bba_pkg::STAT_NONE_FREE;
               state_in           = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = ADDR_W'(addr_ff + 1'b1);
               addr_in   = ADDR_W'(addr_ff + 1'b1);
               word_in   = WORD_W'(word_ff + 1'b1);
            end
         end

         S_DIVIDE: begin
            // one subtraction of the group size per cycle
            if (rem_ff < REM_BPG) begin
               addr_in   = ADDR_W'(group_base(grp_ff)
                                   + ADDR_W'(rem_ff >> bba_pkg::WORD_SHIFT));
               ram_re    = 1'b1;
               ram_raddr = ADDR_W'(group_base(grp_ff)
                                   + ADDR_W'(rem_ff >> bba_pkg::WORD_SHIFT));
               state_in  = S_FREE_WR;
            end else if (grp_ff == GRP_LAST) begin
               res_in.status = bba_pkg::STAT_RANGE;
               state_in      = S_DONE;
            end else begin
               rem_in = REM_W'(rem_ff - REM_BPG);
               grp_in = GRP_W'(grp_ff + 1'b1);
            end
         end

         S_FREE_WR: begin
            // clear the bit, counter saturates at the group size
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = ram_rdata & ~(bba_pkg::WORD_BITS'(1)
                                      << rem_ff[bba_pkg::WORD_SHIFT-1:0]);
            if (cnt_ff[grp_ff] < CNT_FULL) begin
               cnt_in[grp_ff] = CNT_W'(cnt_ff[grp_ff] + 1'b1);
            end
            res_in.status = bba_pkg::STAT_OK;
            state_in      = S_DONE;
         end

         S_DONE: begin
            // hand over once the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         word_ff      <= '0;
         grp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < GROUP_COUNT; g++) begin
            cnt_ff[g] <= CNT_FULL;
         end
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         word_ff      <= word_in;
         grp_ff       <= grp_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   // an accepted request always starts work
   `BBA_ASSERT_NEXT(a_accept_leaves_idle, req_fire, state_ff != S_IDLE)
   // the scan never walks past the group's words
   `BBA_ASSERT_IMPL(a_scan_in_group, state_ff == S_SCAN, word_ff <= WORD_LAST)
   // a bit is only taken from a group whose counter is nonzero
   `BBA_ASSERT_IMPL(a_take_needs_count, state_ff == S_SCAN && ram_we, cnt_ff[grp_ff] != '0)
   // no result while the store is being cleared
   `BBA_ASSERT_IMPL(a_no_rsp_in_clear, state_ff == S_CLEAR, !rsp_valid_ff)
   // free counter of the current group never exceeds the group size
   `BBA_ASSERT(a_count_bound, cnt_ff[grp_ff] <= CNT_FULL)

endmodule

`default_nettype wire
